[hdl/pcl_pkg.sv]
// ----------------------------------------------------------------------------
// pcl_pkg: shared types and constants
// Phase codes, click codes, register indexes, reset values and the
// seven-segment decode for the press classifier.
// ----------------------------------------------------------------------------
package pcl_pkg;

  localparam int unsigned TimerW  = 16;
  localparam int unsigned DebW    = 8;
  localparam int unsigned CountW  = 4;
  localparam int unsigned SegW    = 7;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDatW = 16;

  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_PRESS_DEB = 3'd1,
    PH_HOLD      = 3'd2,
    PH_REL_DEB   = 3'd3,
    PH_SHOW      = 3'd4,
    PH_PAUSE     = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    CLICK_NONE  = 2'd0,
    CLICK_SHORT = 2'd1,
    CLICK_LONG  = 2'd2
  } click_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_DEBOUNCE  = 3'd0,
    REG_LONG_THR  = 3'd1,
    REG_HOLD_TO   = 3'd2,
    REG_SHOW      = 3'd3,
    REG_PAUSE     = 3'd4
  } cfg_reg_t;

  localparam logic [DebW-1:0]   DebounceRst = 8'd30;
  localparam logic [TimerW-1:0] LongThrRst  = 16'd1000;
  localparam logic [TimerW-1:0] HoldToRst   = 16'd5000;
  localparam logic [TimerW-1:0] ShowRst     = 16'd300;
  localparam logic [TimerW-1:0] PauseRst    = 16'd50;
  localparam logic [TimerW-1:0] TimerMax    = '1;

  typedef struct packed {
    logic [DebW-1:0]   debounce_ticks;
    logic [TimerW-1:0] long_threshold;
    logic [TimerW-1:0] hold_timeout;
    logic [TimerW-1:0] show_ticks;
    logic [TimerW-1:0] pause_ticks;
  } cfg_t;

  typedef struct packed {
    phase_t             phase;
    logic [TimerW-1:0]  wait_timer;
    logic [TimerW-1:0]  hold_time;
    logic [CountW-1:0]  hex_count;
    click_t             last_click;
  } state_t;

  typedef struct packed {
    click_t            click_event;
    logic [CountW-1:0] digit_value;
    logic [SegW-1:0]   segment_lights;
    logic              short_lamp;
    logic              long_lamp;
  } result_t;

  // segments a..g, bit6 = a
  function automatic logic [SegW-1:0] seg_decode(input logic [CountW-1:0] d);
    logic [SegW-1:0] s;
    case (d)
      4'h0: s = 7'h7E;
      4'h1: s = 7'h30;
      4'h2: s = 7'h6D;
      4'h3: s = 7'h79;
      4'h4: s = 7'h33;
      4'h5: s = 7'h5B;
      4'h6: s = 7'h5F;
      4'h7: s = 7'h70;
      4'h8: s = 7'h7F;
      4'h9: s = 7'h7B;
      4'hA: s = 7'h77;
      4'hB: s = 7'h1F;
      4'hC: s = 7'h4E;
      4'hD: s = 7'h3D;
      4'hE: s = 7'h4F;
      default: s = 7'h47;
    endcase
    return s;
  endfunction

endpackage

[hdl/pcl_if.sv]
// ----------------------------------------------------------------------------
// pcl interfaces: valid/ready channels
// Tick input, result output and register write channels.
// ----------------------------------------------------------------------------
interface pcl_in_if;
  logic valid;
  logic ready;
  logic button_pressed;
  modport source (output valid, output button_pressed, input ready);
  modport sink   (input valid, input button_pressed, output ready);
endinterface

interface pcl_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] click_event;
  logic [3:0] digit_value;
  logic [6:0] segment_lights;
  logic       short_lamp;
  logic       long_lamp;
  modport source (output valid, output click_event, output digit_value,
                  output segment_lights, output short_lamp, output long_lamp,
                  input ready);
  modport sink   (input valid, input click_event, input digit_value,
                  input segment_lights, input short_lamp, input long_lamp,
                  output ready);
endinterface

interface pcl_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[hdl/pcl_step.sv]
// ----------------------------------------------------------------------------
// pcl_step: per-tick update
// Next phase, timers, count and the result word for one button sample.
// ----------------------------------------------------------------------------
module pcl_step (
  input  pcl_pkg::state_t  cur,
  input  pcl_pkg::cfg_t    cfg,
  input  logic             pressed,
  output pcl_pkg::state_t  nxt,
  output pcl_pkg::result_t res
);
  import pcl_pkg::*;

  logic [TimerW-1:0] timer_inc;
  logic [TimerW-1:0] hold_inc;
  logic              deb_done;
  logic              show_done;
  logic              pause_done;
  click_t            click;
  click_t            kind;
  logic              lit;

  assign timer_inc  = (cur.wait_timer == TimerMax) ? TimerMax : cur.wait_timer + 1'b1;
  assign hold_inc   = (cur.hold_time == TimerMax) ? TimerMax : cur.hold_time + 1'b1;
  assign deb_done   = timer_inc >= {{(TimerW-DebW){1'b0}}, cfg.debounce_ticks};
  assign show_done  = timer_inc >= cfg.show_ticks;
  assign pause_done = timer_inc >= cfg.pause_ticks;

  // next state
  always_comb begin
    nxt   = cur;
    click = CLICK_NONE;
    kind  = CLICK_NONE;
    unique case (cur.phase)
      PH_PRESS_DEB: begin
        nxt.wait_timer = timer_inc;
        if (deb_done) begin
          nxt.wait_timer = '0;
          if (pressed) begin
            nxt.phase     = PH_HOLD;
            nxt.hold_time = '0;
          end else begin
            nxt.phase = PH_PAUSE;
          end
        end
      end
      PH_HOLD: begin
        if (pressed) begin
          nxt.hold_time = hold_inc;
          if (hold_inc > cfg.hold_timeout) kind = CLICK_LONG;
        end else begin
          nxt.phase      = PH_REL_DEB;
          nxt.wait_timer = '0;
        end
      end
      PH_REL_DEB: begin
        nxt.wait_timer = timer_inc;
        if (deb_done) begin
          nxt.wait_timer = '0;
          if (!pressed) begin
            kind = (cur.hold_time < cfg.long_threshold) ? CLICK_SHORT : CLICK_LONG;
          end else begin
            nxt.phase = PH_PAUSE;
          end
        end
      end
      PH_SHOW: begin
        nxt.wait_timer = timer_inc;
        if (show_done) begin
          nxt.wait_timer = '0;
          nxt.last_click = CLICK_NONE;
          nxt.phase      = PH_PAUSE;
        end
      end
      PH_PAUSE: begin
        nxt.wait_timer = timer_inc;
        if (pause_done) begin
          nxt.wait_timer = '0;
          nxt.phase      = pressed ? PH_PRESS_DEB : PH_PAUSE;
        end
      end
      default: begin
        nxt.wait_timer = '0;
        nxt.phase      = pressed ? PH_PRESS_DEB : PH_PAUSE;
      end
    endcase

    // a decided click enters the show phase
    if (kind != CLICK_NONE) begin
      click          = kind;
      nxt.hex_count  = (kind == CLICK_SHORT) ? cur.hex_count + 1'b1 : '0;
      nxt.last_click = kind;
      nxt.phase      = PH_SHOW;
      nxt.wait_timer = '0;
    end
  end

  // outputs reflect the updated state
  always_comb begin
    lit                = (nxt.phase == PH_SHOW);
    res.click_event    = click;
    res.digit_value    = nxt.hex_count;
    res.segment_lights = lit ? seg_decode(nxt.hex_count) : '0;
    res.short_lamp     = lit && (nxt.last_click == CLICK_SHORT);
    res.long_lamp      = lit && (nxt.last_click == CLICK_LONG);
  end

endmodule

[hdl/press_classifier_hex_counter_core.sv]
// ----------------------------------------------------------------------------
// press_classifier_hex_counter_core: short/long press classifier
// Debounced button classifier driving a 4-bit hex counter display.
// ----------------------------------------------------------------------------
// Each input word is one millisecond tick with the button level and yields
// exactly one result word, registered in the cycle after the tick is taken.
// A new tick is taken every cycle in which the input is ready; the only
// loop is the state register around the combinational update logic. While
// a result waits in the output register the input is held off, except in
// the cycle the sink takes that result, so throughput is one tick per cycle whenever the sink takes results.
// Registers are written through the cfg_ channel, which is always ready, and
// should be changed only while no tick is in flight.
module press_classifier_hex_counter_core (
  input  logic         clk,
  input  logic         rst_n,
  pcl_in_if.sink       in_bus,
  pcl_out_if.source    out_bus,
  pcl_cfg_if.sink      cfg_bus
);
  import pcl_pkg::*;

  cfg_t    cfg_r;
  state_t  state_r;
  state_t  state_nxt;
  result_t res_nxt;
  result_t res_r;
  logic    out_valid_r;
  logic    accept;

  assign in_bus.ready  = !out_valid_r || out_bus.ready;
  assign accept        = in_bus.valid && in_bus.ready;
  assign cfg_bus.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_ticks <= DebounceRst;
      cfg_r.long_threshold <= LongThrRst;
      cfg_r.hold_timeout   <= HoldToRst;
      cfg_r.show_ticks     <= ShowRst;
      cfg_r.pause_ticks    <= PauseRst;
    end else if (cfg_bus.valid) begin
      unique case (cfg_bus.index)
        REG_DEBOUNCE: cfg_r.debounce_ticks <= cfg_bus.data[DebW-1:0];
        REG_LONG_THR: cfg_r.long_threshold <= cfg_bus.data;
        REG_HOLD_TO:  cfg_r.hold_timeout   <= cfg_bus.data;
        REG_SHOW:     cfg_r.show_ticks     <= cfg_bus.data;
        REG_PAUSE:    cfg_r.pause_ticks    <= cfg_bus.data;
        default: ;
      endcase
    end
  end

  pcl_step u_step (
    .cur     (state_r),
    .cfg     (cfg_r),
    .pressed (in_bus.button_pressed),
    .nxt     (state_nxt),
    .res     (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.phase      <= PH_IDLE;
      state_r.wait_timer <= '0;
      state_r.hold_time  <= '0;
      state_r.hex_count  <= '0;
      state_r.last_click <= CLICK_NONE;
      out_valid_r        <= 1'b0;
    end else begin
      if (accept) begin
        state_r     <= state_nxt;
        out_valid_r <= 1'b1;
      end else if (out_bus.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) res_r <= res_nxt;
  end

  assign out_bus.valid          = out_valid_r;
  assign out_bus.click_event    = res_r.click_event;
  assign out_bus.digit_value    = res_r.digit_value;
  assign out_bus.segment_lights = res_r.segment_lights;
  assign out_bus.short_lamp     = res_r.short_lamp;
  assign out_bus.long_lamp      = res_r.long_lamp;

endmodule

[hdl/pcl_checker.sv]
// ----------------------------------------------------------------------------
// pcl_checker: port-level checks
// Result channel behavior of the press classifier, bound to the top level.
// ----------------------------------------------------------------------------
module pcl_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] click_event,
  input logic [3:0] digit_value,
  input logic [6:0] segment_lights,
  input logic       short_lamp,
  input logic       long_lamp
);
  import pcl_pkg::*;

  // stalled word holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(click_event)
      && $stable(digit_value) && $stable(segment_lights))
    else $error("result word changed while stalled");

  // display lit exactly while one lamp is on
  a_lit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((segment_lights != '0) == (short_lamp || long_lamp))
      && !(short_lamp && long_lamp))
    else $error("segments and lamps disagree");

  // a short click lights the short lamp
  a_short: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && click_event == CLICK_SHORT |-> short_lamp)
    else $error("short click without short lamp");

  // a long click clears the count and lights the long lamp
  a_long: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && click_event == CLICK_LONG |-> long_lamp && digit_value == '0)
    else $error("long click did not clear count");

endmodule

bind press_classifier_hex_counter_core pcl_checker u_pcl_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_bus.valid),
  .out_ready      (out_bus.ready),
  .click_event    (out_bus.click_event),
  .digit_value    (out_bus.digit_value),
  .segment_lights (out_bus.segment_lights),
  .short_lamp     (out_bus.short_lamp),
  .long_lamp      (out_bus.long_lamp)
);
